// ===== rtl/core/png_scanline_unfilter_core_assert.svh =====
// assertion macros for the png scanline unfilter core
`ifndef PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH

// same-cycle implication
`define PSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/psu_pkg.sv =====
// shared types and constants for the png scanline unfilter core
package psu_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_BPP     = 4;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;
   localparam int COL_BITS    = $clog2(STORE_DEPTH);
   localparam int STRIDE_BITS = COL_BITS + 1;

   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 16;
   localparam int MODE_BITS   = 2;
   localparam int ADDR_BITS   = 4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] FILTER_MAX   = 8'd4;

   localparam logic [MODE_BITS-1:0] MODE_GRAY = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_RGB  = 2'd1;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_COLOR_MODE   = 2'd2
   } psu_csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE    = 3'd0,
      FILT_SUB     = 3'd1,
      FILT_UP      = 3'd2,
      FILT_AVERAGE = 3'd3,
      FILT_PAETH   = 3'd4
   } psu_filter_type;

   typedef enum logic [1:0] {
      KIND_DROP,
      KIND_FILTER,
      KIND_BAD,
      KIND_DATA
   } psu_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } psu_req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic        row_end;
      logic        image_end;
      logic        bad_filter;
   } psu_rsp_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  image_width;
      logic [HEIGHT_BITS-1:0] image_height;
      logic [MODE_BITS-1:0]   color_mode;
   } psu_cfg_type;

   typedef struct packed {
      psu_kind_type         kind;
      logic [7:0]           data_byte;
      psu_filter_type       filter;
      logic                 use_up;
      logic [COL_BITS-1:0]  addr;
      logic                 pix_done;
      logic                 row_done;
      logic                 img_done;
   } psu_op_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
   } psu_rd_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
      logic [7:0]          data;
   } psu_wr_type;

endpackage

// ===== rtl/core/png_scanline_unfilter_core.sv =====
// top level of the png scanline unfilter core
//
// req channel: one byte of the inflated stream per beat, with frame_start on
// the first byte of an image. each row is a filter byte then width times
// bytes-per-pixel sample bytes. rsp channel: one ARGB8888 beat per completed
// pixel with row_end and image_end, or one beat with bad_filter set when a
// filter byte above four arrives, after which bytes are dropped until the
// next frame_start. filter bytes and dropped bytes give no beat.
// throughput: one byte per cycle while rsp_stall is low; a byte goes through a
// sequencing stage that issues the line store read and a reconstruction stage
// that uses the read data and loads the result register.
// the left-neighbor path (paeth predictor plus add) sets the cycle time.
// rsp_stall holds the result register; a byte already in the pipeline waits
// behind it and req_stall rises, so nothing is lost or repeated.
// reset clears counters, neighbor bytes and the pipeline; the line store is
// not cleared and its data is only used after the row above has written it.
// configuration goes through the apb-style port while the block is idle.
module png_scanline_unfilter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  psu_pkg::psu_req_type          req_data,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output psu_pkg::psu_rsp_type          rsp_data,
   input  logic                          rsp_stall,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [psu_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import psu_pkg::*;

   psu_cfg_type cfg;
   psu_op_type  op;
   logic        op_valid;
   logic        advance;
   psu_rd_type  rd;
   psu_wr_type  wr;
   logic [7:0]  ram_rdata;

   psu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   psu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .advance   (advance),
      .op        (op),
      .op_valid  (op_valid),
      .rd        (rd)
   );

   psu_line_ram u_line_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (ram_rdata)
   );

   psu_recon u_recon (
      .clock      (clock),
      .reset      (reset),
      .color_mode (cfg.color_mode),
      .op         (op),
      .op_valid   (op_valid),
      .rd         (rd),
      .ram_rdata  (ram_rdata),
      .advance    (advance),
      .wr         (wr),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

`include "png_scanline_unfilter_core_assert.svh"

   `PSU_ASSERT_NOW(a_bad_beat_clean, clock, reset, rsp_valid && rsp_data.bad_filter, rsp_data.pixel_argb == 32'd0 && !rsp_data.row_end && !rsp_data.image_end, "bad filter beat carries pixel data")
   `PSU_ASSERT_NOW(a_image_end_row_end, clock, reset, rsp_valid && rsp_data.image_end, rsp_data.row_end, "image end without row end")
   `PSU_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, op_valid && rsp_valid && rsp_stall, "input stalled without a blocked result")
   `PSU_ASSERT_NEXT(a_one_write, clock, reset, wr.en, !wr.en || wr.addr != $past(wr.addr), "line store written twice at one column")

endmodule

// ===== rtl/core/psu_csr.sv =====
// configuration registers with apb-style access
module psu_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [psu_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output psu_pkg::psu_cfg_type            cfg
);
   import psu_pkg::*;

   psu_cfg_type       cfg_ff;
   psu_cfg_type       cfg_in;
   logic              wr_en;
   psu_csr_index_type reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = psu_csr_index_type'(paddr[3:2]);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = pwdata[HEIGHT_BITS-1:0];
            CSR_COLOR_MODE:   cfg_in.color_mode   = pwdata[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         CSR_IMAGE_WIDTH:  prdata = {{(32-WIDTH_BITS){1'b0}}, cfg_ff.image_width};
         CSR_IMAGE_HEIGHT: prdata = {{(32-HEIGHT_BITS){1'b0}}, cfg_ff.image_height};
         CSR_COLOR_MODE:   prdata = {{(32-MODE_BITS){1'b0}}, cfg_ff.color_mode};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_BITS'(1);
         cfg_ff.image_height <= HEIGHT_BITS'(1);
         cfg_ff.color_mode   <= MODE_GRAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/psu_ctrl.sv =====
// byte sequencing: filter byte, row and column tracking, line store read issue
module psu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  psu_pkg::psu_cfg_type   cfg,
   input  logic                   req_valid,
   input  psu_pkg::psu_req_type   req_data,
   output logic                   req_stall,
   input  logic                   advance,
   output psu_pkg::psu_op_type    op,
   output logic                   op_valid,
   output psu_pkg::psu_rd_type    rd
);
   import psu_pkg::*;

   logic [HEIGHT_BITS-1:0] row_ff, row_in, row_s;
   logic [COL_BITS-1:0]    col_ff, col_in, col_s;
   logic [1:0]             mod3_ff, mod3_in, mod3_s;
   logic                   exp_ff, exp_in, exp_s;
   logic                   drop_ff, drop_in, drop_s;
   psu_filter_type         filt_ff, filt_in, filt_s;
   psu_op_type             op_ff, op_in, new_op;
   logic                   op_valid_ff, op_valid_in;

   logic                   accept;
   logic [WIDTH_BITS-1:0]  w_eff;
   logic [STRIDE_BITS-1:0] w_ext, stride, col_inc;
   logic [HEIGHT_BITS:0]   h_eff, row_inc;
   logic                   row_done, pix_done, img_done;

   assign req_stall = op_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign op        = op_ff;
   assign op_valid  = op_valid_ff;

   always_comb begin
      if (cfg.image_width == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (cfg.image_width > WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = cfg.image_width;
      end
      w_ext = STRIDE_BITS'(w_eff);
      if (cfg.color_mode == MODE_GRAY) begin
         stride = w_ext;
      end else if (cfg.color_mode == MODE_RGB) begin
         stride = w_ext + (w_ext << 1);
      end else begin
         stride = w_ext << 2;
      end
      h_eff = (cfg.image_height == '0) ? (HEIGHT_BITS+1)'(1)
                                       : {1'b0, cfg.image_height};
   end

   always_comb begin
      row_s  = req_data.frame_start ? '0 : row_ff;
      col_s  = req_data.frame_start ? '0 : col_ff;
      mod3_s = req_data.frame_start ? '0 : mod3_ff;
      exp_s  = req_data.frame_start ? 1'b1 : exp_ff;
      drop_s = req_data.frame_start ? 1'b0 : drop_ff;
      filt_s = req_data.frame_start ? FILT_NONE : filt_ff;

      col_inc  = STRIDE_BITS'(col_s) + STRIDE_BITS'(1);
      row_inc  = (HEIGHT_BITS+1)'(row_s) + (HEIGHT_BITS+1)'(1);
      row_done = col_inc >= stride;
      img_done = row_inc >= h_eff;
      if (cfg.color_mode == MODE_GRAY) begin
         pix_done = 1'b1;
      end else if (cfg.color_mode == MODE_RGB) begin
         pix_done = (mod3_s == 2'd2) || row_done;
      end else begin
         pix_done = (col_s[1:0] == 2'd3) || row_done;
      end

      row_in  = row_s;
      col_in  = col_s;
      mod3_in = mod3_s;
      exp_in  = exp_s;
      drop_in = drop_s;
      filt_in = filt_s;

      new_op           = '0;
      new_op.kind      = KIND_DROP;
      new_op.data_byte = req_data.data_byte;
      new_op.filter    = filt_s;

      if (drop_s) begin
         new_op.kind = KIND_DROP;
      end else if (exp_s) begin
         if (req_data.data_byte > FILTER_MAX) begin
            new_op.kind = KIND_BAD;
            drop_in     = 1'b1;
         end else begin
            new_op.kind = KIND_FILTER;
            filt_in     = psu_filter_type'(req_data.data_byte[2:0]);
            exp_in      = 1'b0;
            col_in      = '0;
            mod3_in     = '0;
         end
      end else begin
         new_op.kind     = KIND_DATA;
         new_op.use_up   = row_s != '0;
         new_op.addr     = col_s;
         new_op.pix_done = pix_done;
         new_op.row_done = row_done;
         new_op.img_done = row_done && img_done;
         if (row_done) begin
            col_in  = '0;
            mod3_in = '0;
            if (img_done) begin
               drop_in = 1'b1;
            end else begin
               row_in = row_inc[HEIGHT_BITS-1:0];
               exp_in = 1'b1;
            end
         end else begin
            col_in  = col_inc[COL_BITS-1:0];
            mod3_in = (mod3_s == 2'd2) ? 2'd0 : mod3_s + 2'd1;
         end
      end

      op_in       = accept ? new_op : op_ff;
      op_valid_in = accept ? 1'b1 : (advance ? 1'b0 : op_valid_ff);
      rd.en       = accept && (new_op.kind == KIND_DATA);
      rd.addr     = col_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         mod3_ff     <= '0;
         exp_ff      <= 1'b1;
         drop_ff     <= 1'b0;
         filt_ff     <= FILT_NONE;
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
         if (accept) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            mod3_ff <= mod3_in;
            exp_ff  <= exp_in;
            drop_ff <= drop_in;
            filt_ff <= filt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

// ===== rtl/core/psu_line_ram.sv =====
// previous-row line store, one write and one registered read per cycle
module psu_line_ram (
   input  logic                          clock,
   input  psu_pkg::psu_wr_type           wr,
   input  psu_pkg::psu_rd_type           rd,
   output logic [7:0]                    rd_data
);
   import psu_pkg::*;

   logic [7:0] mem_ff [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

endmodule

// ===== rtl/core/psu_recon.sv =====
// byte reconstruction, neighbor bytes, pixel packing and result register
module psu_recon (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [psu_pkg::MODE_BITS-1:0] color_mode,
   input  psu_pkg::psu_op_type    op,
   input  logic                   op_valid,
   input  psu_pkg::psu_rd_type    rd,
   input  logic [7:0]             ram_rdata,
   output logic                   advance,
   output psu_pkg::psu_wr_type    wr,
   output logic                   rsp_valid,
   output psu_pkg::psu_rsp_type   rsp_data,
   input  logic                   rsp_stall
);
   import psu_pkg::*;

   logic [7:0]  left_ff [MAX_BPP];
   logic [7:0]  ul_ff   [MAX_BPP];
   logic [23:0] asm_ff;
   logic        fwd_ff;
   logic [7:0]  fwd_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   psu_rsp_type rsp_ff, rsp_in;

   logic [1:0]  nidx;
   logic [7:0]  a, b, c, pred, v;
   logic [8:0]  avg_sum;
   logic signed [9:0] da, db, dc;
   logic [9:0]  pa, pb, pc;
   logic [31:0] full, pixel;
   logic        out_free, emit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = op_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (color_mode == MODE_GRAY) begin
         nidx = 2'd0;
      end else if (color_mode == MODE_RGB) begin
         nidx = 2'd2;
      end else begin
         nidx = 2'd3;
      end
      a = left_ff[nidx];
      c = ul_ff[nidx];
      b = op.use_up ? (fwd_ff ? fwd_data_ff : ram_rdata) : 8'd0;

      avg_sum = {1'b0, a} + {1'b0, b};
      da = $signed({2'b0, b}) - $signed({2'b0, c});
      db = $signed({2'b0, a}) - $signed({2'b0, c});
      dc = da + db;
      pa = da[9] ? 10'(-da) : 10'(da);
      pb = db[9] ? 10'(-db) : 10'(db);
      pc = dc[9] ? 10'(-dc) : 10'(dc);

      unique case (op.filter)
         FILT_SUB:     pred = a;
         FILT_UP:      pred = b;
         FILT_AVERAGE: pred = avg_sum[8:1];
         FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:      pred = 8'd0;
      endcase
      v    = op.data_byte + pred;
      full = {asm_ff, v};

      if (color_mode == MODE_GRAY) begin
         pixel = {ALPHA_OPAQUE, v, v, v};
      end else if (color_mode == MODE_RGB) begin
         pixel = {ALPHA_OPAQUE, full[23:0]};
      end else begin
         pixel = {full[7:0], full[31:8]};
      end

      wr.en   = advance && (op.kind == KIND_DATA);
      wr.addr = op.addr;
      wr.data = v;

      emit   = (op.kind == KIND_BAD) || ((op.kind == KIND_DATA) && op.pix_done);
      rsp_in = rsp_ff;
      if (advance && emit) begin
         if (op.kind == KIND_BAD) begin
            rsp_in = '{pixel_argb: 32'd0, row_end: 1'b0, image_end: 1'b0,
                       bad_filter: 1'b1};
         end else begin
            rsp_in = '{pixel_argb: pixel, row_end: op.row_done,
                       image_end: op.img_done, bad_filter: 1'b0};
         end
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BPP; i++) begin
            left_ff[i] <= 8'd0;
            ul_ff[i]   <= 8'd0;
         end
         asm_ff       <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rd.en) begin
            fwd_ff <= wr.en && (wr.addr == rd.addr);
         end
         if (advance) begin
            unique case (op.kind)
               KIND_FILTER: begin
                  for (int i = 0; i < MAX_BPP; i++) begin
                     left_ff[i] <= 8'd0;
                     ul_ff[i]   <= 8'd0;
                  end
                  asm_ff <= '0;
               end
               KIND_DATA: begin
                  for (int i = 1; i < MAX_BPP; i++) begin
                     left_ff[i] <= left_ff[i-1];
                     ul_ff[i]   <= ul_ff[i-1];
                  end
                  left_ff[0] <= v;
                  ul_ff[0]   <= b;
                  asm_ff     <= op.pix_done ? 24'd0 : full[23:0];
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (rd.en) begin
         fwd_data_ff <= v;
      end
   end

endmodule
